// File: rtl/core/kei_pkg.sv
// Shared types and constants for the keyframe easing interpolator.
// No dependencies.
package kei_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FRAME_BITS = 16;
  localparam int VAL_W      = 32;
  localparam int CURVE_W    = 3;
  localparam int KW         = $clog2(FRAC_BITS);
  localparam int SQ_W       = 2 * FRAC_BITS + 2;
  localparam int CB_W       = 3 * FRAC_BITS + 2;

  localparam logic [CURVE_W-1:0] CURVE_NONE   = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_SQUARE = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_CUBE   = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_SQRT   = 3'd4;
  localparam logic [CURVE_W-1:0] CURVE_CBRT   = 3'd5;

  typedef enum logic [1:0] {
    SEL_CALC,
    SEL_START,
    SEL_END
  } sel_t;

  typedef struct packed {
    sel_t                      sel;
    logic [CURVE_W-1:0]        curve;
    logic                      imode;
    logic signed [VAL_W-1:0]   v0;
    logic signed [VAL_W-1:0]   v1;
  } ctx_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] rem;
    logic [FRAME_BITS-1:0] den;
    logic [FRAC_BITS-1:0]  q;
  } div_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] sq_c;
    logic [SQ_W-1:0]      sq_s;
    logic [FRAC_BITS-1:0] cb_c;
    logic [CB_W-1:0]      cb_s;
    logic [CB_W-1:0]      cb_u;
  } root_t;

endpackage

// File: rtl/core/kei_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on kei_pkg.
interface kei_in_if import kei_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRAME_BITS-1:0]    frame;
  logic [FRAME_BITS-1:0]    start_frame;
  logic [FRAME_BITS-1:0]    end_frame;
  logic signed [VAL_W-1:0]  start_value;
  logic signed [VAL_W-1:0]  end_value;
  logic [CURVE_W-1:0]       curve;
  logic                     integer_mode;
  modport source (output valid, frame, start_frame, end_frame, start_value, end_value,
                  curve, integer_mode, input ready);
  modport sink (input valid, frame, start_frame, end_frame, start_value, end_value,
                curve, integer_mode, output ready);
endinterface

interface kei_out_if import kei_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    at_keyframe;
  modport source (output valid, value, at_keyframe, input ready);
  modport sink (input valid, value, at_keyframe, output ready);
endinterface

// File: rtl/core/kei_div_cell.sv
// One restoring-division cell: produces one quotient bit of progress.
// Depends on kei_pkg.
module kei_div_cell import kei_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ctx_t in_ctx,
  input  div_t in_div,
  output logic out_valid,
  output ctx_t out_ctx,
  output div_t out_div
);
  logic [FRAME_BITS:0] t;
  logic                ge;
  div_t                div_next;

  always_comb begin
    t  = {in_div.rem, 1'b0};
    ge = t >= {1'b0, in_div.den};
    div_next.den = in_div.den;
    div_next.rem = ge ? FRAME_BITS'(t - {1'b0, in_div.den}) : FRAME_BITS'(t);
    div_next.q   = {in_div.q[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_ctx <= in_ctx;
      out_div <= div_next;
    end
  end
endmodule

// File: rtl/core/kei_root_cell.sv
// One bit step of the square root and cube root searches.
// Depends on kei_pkg.
module kei_root_cell import kei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [KW-1:0]        k,
  input  logic                 in_valid,
  input  ctx_t                 in_ctx,
  input  logic [FRAC_BITS-1:0] in_p,
  input  root_t                in_root,
  output logic                 out_valid,
  output ctx_t                 out_ctx,
  output logic [FRAC_BITS-1:0] out_p,
  output root_t                out_root
);
  logic [FRAC_BITS-1:0] bitv;
  logic [SQ_W-1:0]      sq_cand;
  logic [CB_W-1:0]      cb_sq;
  logic [CB_W-1:0]      cb_cu;
  logic [CB_W-1:0]      t1;
  logic [CB_W-1:0]      t2;
  root_t                root_next;

  always_comb begin
    bitv    = FRAC_BITS'(1) << k;
    sq_cand = in_root.sq_s + (SQ_W'(in_root.sq_c) << (k + 1))
              + (SQ_W'(1) << (2 * (KW + 1)'(k)));
    cb_sq   = in_root.cb_s + (CB_W'(in_root.cb_c) << (k + 1))
              + (CB_W'(1) << (2 * (KW + 1)'(k)));
    t1      = in_root.cb_s << k;
    t2      = CB_W'(in_root.cb_c) << (2 * (KW + 1)'(k));
    cb_cu   = in_root.cb_u + t1 + (t1 << 1) + t2 + (t2 << 1)
              + (CB_W'(1) << (3 * (KW + 2)'(k)));
    root_next = in_root;
    if (sq_cand <= (SQ_W'(in_p) << FRAC_BITS)) begin
      root_next.sq_c = in_root.sq_c | bitv;
      root_next.sq_s = sq_cand;
    end
    if (cb_cu <= (CB_W'(in_p) << (2 * FRAC_BITS))) begin
      root_next.cb_c = in_root.cb_c | bitv;
      root_next.cb_s = cb_sq;
      root_next.cb_u = cb_cu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_ctx  <= in_ctx;
      out_p    <= in_p;
      out_root <= root_next;
    end
  end
endmodule

// File: rtl/core/keyframe_easing_interpolator.sv
// Keyframe easing interpolator: a chain of 16 division cells forms the
// progress, 16 root cells shape it, then multiply and output stages finish.
// One transaction per cycle unless the output is stalled. The whole pipeline advances
// together, so it pauses only while a finished result waits at the output.
// Depends on kei_pkg, kei_if, kei_div_cell, kei_root_cell.
module keyframe_easing_interpolator import kei_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  kei_in_if.sink     items_in,
  kei_out_if.source  results_out
);
  logic en;

  logic  dv [0:FRAC_BITS];
  ctx_t  dc [0:FRAC_BITS];
  div_t  dd [0:FRAC_BITS];
  logic  rv [0:FRAC_BITS];
  ctx_t  rc [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] rp [0:FRAC_BITS];
  root_t rr [0:FRAC_BITS];

  logic                    m1_valid;
  ctx_t                    m1_ctx;
  logic [FRAC_BITS-1:0]    m1_p;
  logic [FRAC_BITS-1:0]    m1_sq;
  logic [FRAC_BITS-1:0]    m1_cb;
  logic [2*FRAC_BITS-1:0]  m1_pp;

  logic                    m2_valid;
  ctx_t                    m2_ctx;
  logic [FRAC_BITS-1:0]    m2_s;
  logic signed [VAL_W:0]   m2_d;
  logic [FRAC_BITS-1:0]    s_next;
  logic [3*FRAC_BITS-1:0]  cube;

  localparam int PW = VAL_W + FRAC_BITS + 2;
  logic                    m3_valid;
  ctx_t                    m3_ctx;
  logic signed [PW-1:0]    m3_prod;

  logic                    m4_valid;
  logic signed [VAL_W-1:0] m4_value;
  logic                    m4_atk;
  logic signed [VAL_W-1:0] value_next;
  logic signed [VAL_W-1:0] kv;
  logic signed [VAL_W:0]   kv_b;
  logic signed [PW:0]      pr_b;
  logic signed [PW+2:0]    n_w;
  logic signed [PW+2:0]    n_b;

  assign en             = !m4_valid || results_out.ready;
  assign items_in.ready = en;

  always_comb begin
    dv[0] = items_in.valid;
    dc[0].curve = items_in.curve;
    dc[0].imode = items_in.integer_mode;
    dc[0].v0    = items_in.start_value;
    dc[0].v1    = items_in.end_value;
    if (items_in.end_frame <= items_in.start_frame
        || items_in.frame >= items_in.end_frame) begin
      dc[0].sel = SEL_END;
    end else if (items_in.frame <= items_in.start_frame
                 || !(items_in.curve inside {[CURVE_LINEAR:CURVE_CBRT]})) begin
      dc[0].sel = SEL_START;
    end else begin
      dc[0].sel = SEL_CALC;
    end
    dd[0].rem = items_in.frame - items_in.start_frame;
    dd[0].den = items_in.end_frame - items_in.start_frame;
    dd[0].q   = '0;
    rv[0] = dv[FRAC_BITS];
    rc[0] = dc[FRAC_BITS];
    rp[0] = dd[FRAC_BITS].q;
    rr[0] = '0;
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_chain
    kei_div_cell u_div (
      .clk, .rst, .en,
      .in_valid (dv[i]), .in_ctx (dc[i]), .in_div (dd[i]),
      .out_valid(dv[i+1]), .out_ctx(dc[i+1]), .out_div(dd[i+1])
    );
    kei_root_cell u_root (
      .clk, .rst, .en,
      .k        (KW'(FRAC_BITS - 1 - i)),
      .in_valid (rv[i]), .in_ctx (rc[i]), .in_p (rp[i]), .in_root (rr[i]),
      .out_valid(rv[i+1]), .out_ctx(rc[i+1]), .out_p(rp[i+1]), .out_root(rr[i+1])
    );
  end

  always_comb begin
    cube = (3*FRAC_BITS)'(m1_pp) * (3*FRAC_BITS)'(m1_p);
    case (m1_ctx.curve)
      CURVE_LINEAR: s_next = m1_p;
      CURVE_SQUARE: s_next = m1_pp[2*FRAC_BITS-1:FRAC_BITS];
      CURVE_CUBE:   s_next = cube[3*FRAC_BITS-1:2*FRAC_BITS];
      CURVE_SQRT:   s_next = m1_sq;
      CURVE_CBRT:   s_next = m1_cb;
      default:      s_next = '0;
    endcase
  end

  always_comb begin
    kv   = (m3_ctx.sel == SEL_END) ? m3_ctx.v1 : m3_ctx.v0;
    kv_b = (VAL_W+1)'(kv) + (kv[VAL_W-1] ? (VAL_W+1)'((1 << FRAC_BITS) - 1) : '0);
    pr_b = (PW+1)'(m3_prod)
           + (m3_prod[PW-1] ? (PW+1)'((64'd1 << FRAC_BITS) - 1) : '0);
    n_w  = ((PW+3)'(m3_ctx.v0) <<< FRAC_BITS) + (PW+3)'(m3_prod);
    n_b  = n_w + (n_w[PW+2] ? (PW+3)'((64'd1 << (2*FRAC_BITS)) - 1) : '0);
    if (m3_ctx.sel != SEL_CALC) begin
      value_next = m3_ctx.imode ? VAL_W'((kv_b >>> FRAC_BITS) <<< FRAC_BITS) : kv;
    end else if (m3_ctx.imode) begin
      value_next = VAL_W'((n_b >>> (2*FRAC_BITS)) <<< FRAC_BITS);
    end else begin
      value_next = m3_ctx.v0 + VAL_W'(pr_b >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= rv[FRAC_BITS];
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
    if (en) begin
      m1_ctx   <= rc[FRAC_BITS];
      m1_p     <= rp[FRAC_BITS];
      m1_sq    <= rr[FRAC_BITS].sq_c;
      m1_cb    <= rr[FRAC_BITS].cb_c;
      m1_pp    <= (2*FRAC_BITS)'(rp[FRAC_BITS]) * (2*FRAC_BITS)'(rp[FRAC_BITS]);
      m2_ctx   <= m1_ctx;
      m2_s     <= s_next;
      m2_d     <= (VAL_W+1)'(m1_ctx.v1) - (VAL_W+1)'(m1_ctx.v0);
      m3_ctx   <= m2_ctx;
      m3_prod  <= PW'(m2_d) * PW'($signed({2'b0, m2_s}));
      m4_value <= value_next;
      m4_atk   <= (m3_ctx.sel == SEL_END);
    end
  end

  assign results_out.valid       = m4_valid;
  assign results_out.value       = m4_value;
  assign results_out.at_keyframe = m4_atk;

  a_ready: assert property (@(posedge clk) disable iff (rst)
    items_in.ready == (!m4_valid || results_out.ready)) else $error("ready mismatch");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    en && m3_valid |=> m4_valid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(m4_value) && $stable(m4_atk)) else $error("output changed in stall");
endmodule
